FILE: src/kcd_pkg.sv
// Shared constants for the keystroke command decoder: modes, actions, key codes.
`timescale 1ns / 1ps
`default_nettype none
package kcd_pkg;

   // field widths
   localparam int KeyWidth    = 8;
   localparam int LinesWidth  = 16;
   localparam int ActionWidth = 4;
   localparam int CharWidth   = 7;
   localparam int LineWidth   = 14;
   localparam int ModeWidth   = 2;

   // decoder modes
   localparam logic [ModeWidth-1:0] ModeNormal = 2'd0;
   localparam logic [ModeWidth-1:0] ModeEsc1   = 2'd1;
   localparam logic [ModeWidth-1:0] ModeEsc2   = 2'd2;
   localparam logic [ModeWidth-1:0] ModeGoto   = 2'd3;

   // largest goto number before it wraps to zero
   localparam logic [LineWidth-1:0] GotoMax = 14'd9999;

   // result actions
   localparam logic [ActionWidth-1:0] ActInsert  = 4'd0;
   localparam logic [ActionWidth-1:0] ActNewline = 4'd1;
   localparam logic [ActionWidth-1:0] ActDelBack = 4'd2;
   localparam logic [ActionWidth-1:0] ActLStart  = 4'd3;
   localparam logic [ActionWidth-1:0] ActLEnd    = 4'd4;
   localparam logic [ActionWidth-1:0] ActRedraw  = 4'd5;
   localparam logic [ActionWidth-1:0] ActSave    = 4'd6;
   localparam logic [ActionWidth-1:0] ActQuit    = 4'd7;
   localparam logic [ActionWidth-1:0] ActRight   = 4'd8;
   localparam logic [ActionWidth-1:0] ActLeft    = 4'd9;
   localparam logic [ActionWidth-1:0] ActUp      = 4'd10;
   localparam logic [ActionWidth-1:0] ActDown    = 4'd11;
   localparam logic [ActionWidth-1:0] ActDigit   = 4'd12;
   localparam logic [ActionWidth-1:0] ActGoto    = 4'd13;

   // key codes
   localparam logic [KeyWidth-1:0] KeyCtrlA  = 8'd1;
   localparam logic [KeyWidth-1:0] KeyCtrlG  = 8'd7;
   localparam logic [KeyWidth-1:0] KeyBs     = 8'd8;
   localparam logic [KeyWidth-1:0] KeyTab    = 8'd9;
   localparam logic [KeyWidth-1:0] KeyLf     = 8'd10;
   localparam logic [KeyWidth-1:0] KeyCtrlQ  = 8'd17;
   localparam logic [KeyWidth-1:0] KeyCtrlR  = 8'd18;
   localparam logic [KeyWidth-1:0] KeyCtrlW  = 8'd23;
   localparam logic [KeyWidth-1:0] KeyCtrlZ  = 8'd26;
   localparam logic [KeyWidth-1:0] KeyEsc    = 8'd27;
   localparam logic [KeyWidth-1:0] KeySpace  = 8'd32;
   localparam logic [KeyWidth-1:0] KeyZero   = 8'd48;
   localparam logic [KeyWidth-1:0] KeyNine   = 8'd57;
   localparam logic [KeyWidth-1:0] KeyUpA    = 8'd65;
   localparam logic [KeyWidth-1:0] KeyDownB  = 8'd66;
   localparam logic [KeyWidth-1:0] KeyRightC = 8'd67;
   localparam logic [KeyWidth-1:0] KeyLeftD  = 8'd68;
   localparam logic [KeyWidth-1:0] KeyBrack  = 8'd91;
   localparam logic [KeyWidth-1:0] KeyTilde  = 8'd126;
   localparam logic [KeyWidth-1:0] KeyDel    = 8'd127;

endpackage
`default_nettype wire

FILE: src/keystroke_command_decoder.sv
// Top level of the keystroke command decoder: key bytes in, editor commands out.
`timescale 1ns / 1ps
`default_nettype none
// A key beat waits in the input stage and is decoded into the result register behind rsp_.
// Throughput: one key beat per cycle; while a result waits on rsp_stall the input
//   stage takes one more beat, then req_stall rises until the result leaves.
// Bytes that give no command leave no beat on rsp_.
// Reset (synchronous, active high): normal mode, not quit, goto number 0, stages empty.
module keystroke_command_decoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [kcd_pkg::KeyWidth-1:0]        req_key_byte,
   input  wire logic [kcd_pkg::LinesWidth-1:0]      req_line_count,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [kcd_pkg::ActionWidth-1:0]     rsp_action,
   output      logic [kcd_pkg::CharWidth-1:0]       rsp_char_value,
   output      logic [kcd_pkg::LineWidth-1:0]       rsp_line_number
);

   // ---------------------------------------------------------------
   // Input stage: one key beat waiting to be decoded
   // ---------------------------------------------------------------
   logic                               in_valid_ff;
   logic [kcd_pkg::KeyWidth-1:0]       key_ff;
   logic [kcd_pkg::LinesWidth-1:0]     lines_ff;

   // Result register
   logic                               out_valid_ff;
   logic [kcd_pkg::ActionWidth-1:0]    action_ff;
   logic [kcd_pkg::CharWidth-1:0]      char_ff;
   logic [kcd_pkg::LineWidth-1:0]      line_ff;

   // Decoder state
   logic [kcd_pkg::ModeWidth-1:0]      mode_ff,    mode_in;
   logic                               stopped_ff, stopped_in;
   logic                               bracket_ff, bracket_in;
   logic [kcd_pkg::LineWidth-1:0]      goto_ff,    goto_in;

   // Decode results for the beat in the input stage
   logic                               emit;
   logic [kcd_pkg::ActionWidth-1:0]    act;
   logic [kcd_pkg::CharWidth-1:0]      chr;
   logic [kcd_pkg::LineWidth-1:0]      line;

   // Goto arithmetic: value*10 + digit fits in 17 bits since value <= 9999
   logic [16:0]                        goto_wide;
   logic [16:0]                        goto_next;
   logic [kcd_pkg::LineWidth-1:0]      goto_target;
   logic                               is_digit;

   logic out_free;   // result register can take a beat this cycle
   logic advance;    // input-stage beat is decoded and retired this cycle

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign rsp_valid       = out_valid_ff;
   assign rsp_action      = action_ff;
   assign rsp_char_value  = char_ff;
   assign rsp_line_number = line_ff;

   assign is_digit  = (key_ff >= kcd_pkg::KeyZero) && (key_ff <= kcd_pkg::KeyNine);
   assign goto_wide = ({3'b000, goto_ff} << 3) + ({3'b000, goto_ff} << 1);
   assign goto_next = goto_wide + {13'd0, key_ff[3:0]};

   // Clamp goto target to at least 1, then to at most line_count.
   always_comb begin
      logic [kcd_pkg::LineWidth-1:0] raised;
      raised = (goto_ff == '0) ? kcd_pkg::LineWidth'(1) : goto_ff;
      if ({2'b00, raised} > lines_ff) begin
         goto_target = lines_ff[kcd_pkg::LineWidth-1:0];
      end else begin
         goto_target = raised;
      end
   end

   // ---------------------------------------------------------------
   // Decode: one beat, one mode step
   // ---------------------------------------------------------------
   always_comb begin
      emit       = 1'b0;
      act        = kcd_pkg::ActInsert;
      chr        = '0;
      line       = '0;
      mode_in    = mode_ff;
      stopped_in = stopped_ff;
      bracket_in = bracket_ff;
      goto_in    = goto_ff;

      if (!stopped_ff) begin
         unique case (mode_ff)
            kcd_pkg::ModeGoto: begin
               emit = 1'b1;
               if (is_digit) begin
                  act = kcd_pkg::ActDigit;
                  // above the limit the number wraps to zero
                  if (goto_next > {3'b000, kcd_pkg::GotoMax}) begin
                     goto_in = '0;
                  end else begin
                     goto_in = goto_next[kcd_pkg::LineWidth-1:0];
                  end
                  line = goto_in;
               end else begin
                  act     = kcd_pkg::ActGoto;
                  line    = goto_target;
                  mode_in = kcd_pkg::ModeNormal;
               end
            end
            kcd_pkg::ModeEsc1: begin
               bracket_in = (key_ff == kcd_pkg::KeyBrack);
               mode_in    = kcd_pkg::ModeEsc2;
            end
            kcd_pkg::ModeEsc2: begin
               mode_in = kcd_pkg::ModeNormal;
               if (bracket_ff) begin
                  case (key_ff)
                     kcd_pkg::KeyRightC: begin emit = 1'b1; act = kcd_pkg::ActRight; end
                     kcd_pkg::KeyLeftD:  begin emit = 1'b1; act = kcd_pkg::ActLeft;  end
                     kcd_pkg::KeyUpA:    begin emit = 1'b1; act = kcd_pkg::ActUp;    end
                     kcd_pkg::KeyDownB:  begin emit = 1'b1; act = kcd_pkg::ActDown;  end
                     default: ;  // unknown escape: no command
                  endcase
               end
            end
            kcd_pkg::ModeNormal: begin
               unique case (key_ff) inside
                  kcd_pkg::KeyCtrlQ: begin
                     emit       = 1'b1;
                     act        = kcd_pkg::ActQuit;
                     stopped_in = 1'b1;
                  end
                  kcd_pkg::KeyCtrlR: begin emit = 1'b1; act = kcd_pkg::ActRedraw; end
                  kcd_pkg::KeyCtrlA: begin emit = 1'b1; act = kcd_pkg::ActLStart; end
                  kcd_pkg::KeyCtrlZ: begin emit = 1'b1; act = kcd_pkg::ActLEnd;   end
                  kcd_pkg::KeyCtrlG: begin
                     goto_in = '0;
                     mode_in = kcd_pkg::ModeGoto;
                  end
                  kcd_pkg::KeyCtrlW: begin emit = 1'b1; act = kcd_pkg::ActSave;    end
                  kcd_pkg::KeyLf:    begin emit = 1'b1; act = kcd_pkg::ActNewline; end
                  kcd_pkg::KeyDel, kcd_pkg::KeyBs: begin
                     emit = 1'b1;
                     act  = kcd_pkg::ActDelBack;
                  end
                  [kcd_pkg::KeySpace:kcd_pkg::KeyTilde], kcd_pkg::KeyTab: begin
                     emit = 1'b1;
                     act  = kcd_pkg::ActInsert;
                     chr  = key_ff[kcd_pkg::CharWidth-1:0];
                  end
                  default: ;  // other control codes and high bytes: nothing
               endcase
            end
            default: ;
         endcase

         // ESC always restarts an escape sequence, whatever mode it ended
         if (key_ff == kcd_pkg::KeyEsc) begin
            mode_in    = kcd_pkg::ModeEsc1;
            bracket_in = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= kcd_pkg::ModeNormal;
         stopped_ff   <= 1'b0;
         bracket_ff   <= 1'b0;
         goto_ff      <= '0;
      end else begin
         // input stage loads whenever it is empty or retiring its beat
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= advance && emit;
         end
         if (advance) begin
            mode_ff    <= mode_in;
            stopped_ff <= stopped_in;
            bracket_ff <= bracket_in;
            goto_ff    <= goto_in;
         end
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         key_ff   <= req_key_byte;
         lines_ff <= req_line_count;
      end
      if (advance && emit) begin
         action_ff <= act;
         char_ff   <= chr;
         line_ff   <= line;
      end
   end

endmodule
`default_nettype wire
